### sv/rdm_pkg.sv
`default_nettype none

package rdm_pkg;

    localparam int SPD_W      = 12;
    localparam int TRN_W      = 13;
    localparam int SPD_CFG_W  = 11;
    localparam int TRN_CFG_W  = 12;
    localparam int HT_W       = 8;
    localparam int RATE_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // ramp unit ports carry the wider angular channel
    localparam int RAMP_W     = TRN_W;
    localparam int RAMP_CFG_W = TRN_CFG_W;
    localparam int RAMP_INT_W = 16;

    // wheel mixing: 100*V -/+ h*W stays below 2^21 in magnitude
    localparam int MIX_W       = 23;
    localparam int MAG_W       = 21;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int RECIP_SHIFT = 30;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    localparam logic [MAG_W-1:0]  RECIP       = 21'd1073742;
    localparam logic [6:0]        SPEED_SCALE = 7'd100;
    localparam logic [RATE_W-1:0] RATE_SAT    = 10'd1023;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP_MAX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK     = 3'd6;

    typedef struct packed {
        logic [SPD_CFG_W-1:0] speed_step_max;
        logic [SPD_CFG_W-1:0] speed_step_min;
        logic [SPD_CFG_W-1:0] speed_limit;
        logic [TRN_CFG_W-1:0] turn_step_max;
        logic [TRN_CFG_W-1:0] turn_step_min;
        logic [TRN_CFG_W-1:0] turn_limit;
        logic [HT_W-1:0]      half_track;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        speed_step_max: 11'd120,
        speed_step_min: 11'd10,
        speed_limit:    11'd1200,
        turn_step_max:  12'd200,
        turn_step_min:  12'd10,
        turn_limit:     12'd2400,
        half_track:     8'd20
    };

endpackage

`default_nettype wire

### sv/rdm_if.sv
`default_nettype none

interface rdm_in_if;
    import rdm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] speed_target;
    logic signed [SPD_W-1:0] speed_step;
    logic signed [TRN_W-1:0] turn_target;
    logic signed [TRN_W-1:0] turn_step;

    modport source (
        output valid, speed_target, speed_step, turn_target, turn_step,
        input  ready
    );
    modport sink (
        input  valid, speed_target, speed_step, turn_target, turn_step,
        output ready
    );
endinterface

interface rdm_out_if;
    import rdm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    left_forward;
    logic [RATE_W-1:0]       left_rate;
    logic                    right_forward;
    logic [RATE_W-1:0]       right_rate;
    logic signed [SPD_W-1:0] speed_now;
    logic signed [TRN_W-1:0] turn_now;

    modport source (
        output valid, left_forward, left_rate, right_forward, right_rate,
               speed_now, turn_now,
        input  ready
    );
    modport sink (
        input  valid, left_forward, left_rate, right_forward, right_rate,
               speed_now, turn_now,
        output ready
    );
endinterface

interface rdm_cfg_if;
    import rdm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/rdm_cfg.sv
`default_nettype none

module rdm_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [rdm_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [rdm_pkg::CFG_DATA_W-1:0] i_wr_data,
    output rdm_pkg::t_cfg                       o_cfg
);
    import rdm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_SPEED_STEP_MAX: n_cfg.speed_step_max = i_wr_data[SPD_CFG_W-1:0];
                CFG_SPEED_STEP_MIN: n_cfg.speed_step_min = i_wr_data[SPD_CFG_W-1:0];
                CFG_SPEED_LIMIT:    n_cfg.speed_limit    = i_wr_data[SPD_CFG_W-1:0];
                CFG_TURN_STEP_MAX:  n_cfg.turn_step_max  = i_wr_data[TRN_CFG_W-1:0];
                CFG_TURN_STEP_MIN:  n_cfg.turn_step_min  = i_wr_data[TRN_CFG_W-1:0];
                CFG_TURN_LIMIT:     n_cfg.turn_limit     = i_wr_data[TRN_CFG_W-1:0];
                CFG_HALF_TRACK:     n_cfg.half_track     = i_wr_data[HT_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/rdm_ramp.sv
`default_nettype none

module rdm_ramp (
    input  wire logic signed [rdm_pkg::RAMP_W-1:0] i_cur,
    input  wire logic signed [rdm_pkg::RAMP_W-1:0] i_tar,
    input  wire logic signed [rdm_pkg::RAMP_W-1:0] i_step,
    input  wire logic [rdm_pkg::RAMP_CFG_W-1:0]    i_smax,
    input  wire logic [rdm_pkg::RAMP_CFG_W-1:0]    i_smin,
    input  wire logic [rdm_pkg::RAMP_CFG_W-1:0]    i_lim,
    output logic signed [rdm_pkg::RAMP_W-1:0]      o_next
);
    import rdm_pkg::*;

    logic signed [RAMP_INT_W-1:0] cur;
    logic signed [RAMP_INT_W-1:0] tar;
    logic signed [RAMP_INT_W-1:0] smax;
    logic signed [RAMP_INT_W-1:0] smin;
    logic signed [RAMP_INT_W-1:0] lim;
    logic signed [RAMP_INT_W-1:0] d;
    logic signed [RAMP_INT_W-1:0] d_abs;
    logic signed [RAMP_INT_W-1:0] sum;
    logic signed [RAMP_INT_W-1:0] diff;
    logic signed [RAMP_INT_W-1:0] diff_abs;
    logic signed [RAMP_INT_W-1:0] val;

    assign cur  = RAMP_INT_W'(i_cur);
    assign tar  = RAMP_INT_W'(i_tar);
    assign smax = $signed(RAMP_INT_W'(i_smax));
    assign smin = $signed(RAMP_INT_W'(i_smin));
    assign lim  = $signed(RAMP_INT_W'(i_lim));

    always_comb begin
        d = RAMP_INT_W'(i_step);
        if (d < -smax) d = -smax;
        if (d > smax) d = smax;
        d_abs = (d < 0) ? -d : d;
        // small nonzero steps are raised to the minimum
        if (d_abs < smin) begin
            if (d > 0) begin
                d = smin;
            end else if (d < 0) begin
                d = -smin;
            end
        end
        sum      = cur + d;
        diff     = sum - tar;
        diff_abs = (diff < 0) ? -diff : diff;
        if (diff_abs < smax) sum = tar;
        val = (cur != tar) ? sum : cur;
        if (val > lim) val = lim;
        if (val < -lim) val = -lim;
    end

    assign o_next = val[RAMP_W-1:0];

endmodule

`default_nettype wire

### sv/rdm_wheel.sv
`default_nettype none

module rdm_wheel (
    input  wire logic signed [rdm_pkg::MIX_W-1:0] i_val,
    output logic                                  o_fwd,
    output logic [rdm_pkg::RATE_W-1:0]            o_rate
);
    import rdm_pkg::*;

    logic signed [MIX_W-1:0] val_abs;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [QUO_W-1:0]        quo;

    assign val_abs = (i_val < 0) ? -i_val : i_val;
    assign mag     = val_abs[MAG_W-1:0];

    // divide by 1000 through the reciprocal, exact over the magnitude range
    assign prod = PROD_W'(mag) * PROD_W'(RECIP);
    assign quo  = prod[RECIP_SHIFT +: QUO_W];

    assign o_fwd  = (i_val > 0);
    assign o_rate = (quo > QUO_W'(RATE_SAT)) ? RATE_SAT : quo[RATE_W-1:0];

endmodule

`default_nettype wire

### sv/ramped_differential_drive_mixer.sv
// Ramped differential drive mixer.
// Input channel i_in: one word per control tick with the linear and angular
// targets and the signed step for each. Output channel o_out: one word per tick
// in which either ramped value moved, with the left and right wheel direction
// and rate and the new linear and angular values. Ticks that move nothing
// update the state and give no output word.
// Configuration channel i_cfg: register index and data, always ready; it is to be
// written only while no word is in flight, which the user must ensure, as the block does not enforce it.
// From input acceptance a word passes through the input register, the ramp and
// state update into stage one, the wheel mixing multiply into stage two, then
// the divide by a thousand and saturation into the output register.
// Throughput is one word per cycle while the receiver does not stall; the ramp
// state closes its loop through its own register, so consecutive ticks go
// through back to back. When the receiver stalls, words stay in the output
// register and the stages behind it fill up before i_in.ready drops; ready returns
// as soon as any stage frees. Synchronous reset clears the ramped values to zero,
// empties all stages and loads the register reset values.
`default_nettype none

module ramped_differential_drive_mixer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rdm_in_if.sink     i_in,
    rdm_out_if.source  o_out,
    rdm_cfg_if.sink    i_cfg
);
    import rdm_pkg::*;

    t_cfg w_cfg;

    logic r_in_valid;
    logic signed [SPD_W-1:0] r_in_speed_target;
    logic signed [SPD_W-1:0] r_in_speed_step;
    logic signed [TRN_W-1:0] r_in_turn_target;
    logic signed [TRN_W-1:0] r_in_turn_step;

    logic signed [SPD_W-1:0] r_lin;
    logic signed [TRN_W-1:0] r_ang;
    logic signed [SPD_W-1:0] n_lin;
    logic signed [TRN_W-1:0] n_ang;
    logic signed [RAMP_W-1:0] ramp_lin;

    logic r_s1_valid;
    logic signed [SPD_W-1:0] r_s1_lin;
    logic signed [TRN_W-1:0] r_s1_ang;

    logic r_s2_valid;
    logic signed [MIX_W-1:0] r_s2_left;
    logic signed [MIX_W-1:0] r_s2_right;
    logic signed [SPD_W-1:0] r_s2_lin;
    logic signed [TRN_W-1:0] r_s2_ang;

    logic signed [MIX_W-1:0] n_hw;
    logic signed [MIX_W-1:0] n_pv;

    logic              n_left_fwd;
    logic [RATE_W-1:0] n_left_rate;
    logic              n_right_fwd;
    logic [RATE_W-1:0] n_right_rate;

    logic r_out_valid;
    logic r_out_left_fwd;
    logic [RATE_W-1:0] r_out_left_rate;
    logic r_out_right_fwd;
    logic [RATE_W-1:0] r_out_right_rate;
    logic signed [SPD_W-1:0] r_out_lin;
    logic signed [TRN_W-1:0] r_out_ang;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic in_free;
    logic step_fire;
    logic changed;

    assign i_cfg.ready = 1'b1;

    rdm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    // stage occupancy
    assign out_free  = !r_out_valid || o_out.ready;
    assign s2_free   = !r_s2_valid || out_free;
    assign s1_free   = !r_s1_valid || s2_free;
    assign in_free   = !r_in_valid || s1_free;
    assign step_fire = r_in_valid && s1_free;

    assign i_in.ready = in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in_speed_target <= i_in.speed_target;
            r_in_speed_step   <= i_in.speed_step;
            r_in_turn_target  <= i_in.turn_target;
            r_in_turn_step    <= i_in.turn_step;
        end
    end

    // ramp both channels against the current state
    rdm_ramp u_ramp_lin (
        .i_cur  (RAMP_W'(r_lin)),
        .i_tar  (RAMP_W'(r_in_speed_target)),
        .i_step (RAMP_W'(r_in_speed_step)),
        .i_smax (RAMP_CFG_W'(w_cfg.speed_step_max)),
        .i_smin (RAMP_CFG_W'(w_cfg.speed_step_min)),
        .i_lim  (RAMP_CFG_W'(w_cfg.speed_limit)),
        .o_next (ramp_lin)
    );

    rdm_ramp u_ramp_ang (
        .i_cur  (r_ang),
        .i_tar  (r_in_turn_target),
        .i_step (r_in_turn_step),
        .i_smax (w_cfg.turn_step_max),
        .i_smin (w_cfg.turn_step_min),
        .i_lim  (w_cfg.turn_limit),
        .o_next (n_ang)
    );

    assign n_lin   = ramp_lin[SPD_W-1:0];
    assign changed = (n_lin != r_lin) || (n_ang != r_ang);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin      <= '0;
            r_ang      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (step_fire) begin
                r_lin <= n_lin;
                r_ang <= n_ang;
            end
            if (s1_free) begin
                r_s1_valid <= r_in_valid && changed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_lin <= n_lin;
            r_s1_ang <= n_ang;
        end
    end

    // wheel mixing
    assign n_hw = MIX_W'(r_s1_ang) * $signed(MIX_W'(w_cfg.half_track));
    assign n_pv = MIX_W'(r_s1_lin) * $signed(MIX_W'(SPEED_SCALE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_s2_left  <= n_pv - n_hw;
            r_s2_right <= -(n_pv + n_hw);
            r_s2_lin   <= r_s1_lin;
            r_s2_ang   <= r_s1_ang;
        end
    end

    rdm_wheel u_wheel_left (
        .i_val  (r_s2_left),
        .o_fwd  (n_left_fwd),
        .o_rate (n_left_rate)
    );

    rdm_wheel u_wheel_right (
        .i_val  (r_s2_right),
        .o_fwd  (n_right_fwd),
        .o_rate (n_right_rate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_left_fwd   <= n_left_fwd;
            r_out_left_rate  <= n_left_rate;
            r_out_right_fwd  <= n_right_fwd;
            r_out_right_rate <= n_right_rate;
            r_out_lin        <= r_s2_lin;
            r_out_ang        <= r_s2_ang;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.left_forward  = r_out_left_fwd;
    assign o_out.left_rate     = r_out_left_rate;
    assign o_out.right_forward = r_out_right_fwd;
    assign o_out.right_rate    = r_out_right_rate;
    assign o_out.speed_now     = r_out_lin;
    assign o_out.turn_now      = r_out_ang;

    // state moves only on a ramp step
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step_fire |=> $stable(r_lin) && $stable(r_ang))
        else $error("ramp state changed without a step");

    a_speed_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire |=> (RAMP_W'(r_lin) <= $signed({2'b00, $past(w_cfg.speed_limit)}))
                   && (RAMP_W'(r_lin) >= -$signed({2'b00, $past(w_cfg.speed_limit)})))
        else $error("linear value beyond its limit");

    a_turn_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire |=> (r_ang <= $signed({1'b0, $past(w_cfg.turn_limit)}))
                   && (r_ang >= -$signed({1'b0, $past(w_cfg.turn_limit)})))
        else $error("angular value beyond its limit");

    a_s1_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_free |=> r_s1_valid && $stable(r_s1_lin) && $stable(r_s1_ang))
        else $error("ramped word lost under stall");

endmodule

`default_nettype wire

### dv/ramped_differential_drive_mixer_checker.sv
module rdm_drive_check (
    input  logic i_clk,
    input  logic i_rst_n,
    rdm_in_if    i_tick,
    rdm_out_if   i_drive,
    rdm_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_word_count
);
    import rdm_pkg::*;

    typedef struct {
        logic                    left_forward;
        logic [RATE_W-1:0]       left_rate;
        logic                    right_forward;
        logic [RATE_W-1:0]       right_rate;
        logic signed [SPD_W-1:0] speed_now;
        logic signed [TRN_W-1:0] turn_now;
    } t_drive_word;

    t_cfg        regs;
    int          linear_now;
    int          angular_now;
    t_drive_word drive_words_due[$];
    int          fail_count = 0;
    int          word_count = 0;
    int          pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_word_count = word_count;

    function automatic int ramp_toward(input int cur, input int target, input int step,
                                       input int step_max, input int step_min,
                                       input int limit);
        int delta;
        int gap;
        if (cur != target) begin
            delta = step;
            if (delta < -step_max) delta = -step_max;
            if (delta > step_max) delta = step_max;
            // min applied after max, so a crossed pair lets the min win
            if (delta != 0 && (delta < 0 ? -delta : delta) < step_min) begin
                delta = (delta > 0) ? step_min : -step_min;
            end
            cur = cur + delta;
            gap = cur - target;
            if ((gap < 0 ? -gap : gap) < step_max) cur = target;
        end
        if (cur > limit) cur = limit;
        if (cur < -limit) cur = -limit;
        return cur;
    endfunction

    function automatic void wheel_of(input int mix, output logic forward,
                                     output logic [RATE_W-1:0] rate);
        int mag;
        mag = (mix < 0 ? -mix : mix) / 1000;
        forward = (mix > 0);
        rate = (mag > int'(RATE_SAT)) ? RATE_SAT : RATE_W'(mag);
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_drive_word want;
        int          v;
        int          w;
        int          hw;
        if (!i_rst_n) begin
            regs = CFG_RESET;
            linear_now = 0;
            angular_now = 0;
            drive_words_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SPEED_STEP_MAX: regs.speed_step_max = i_cfg.data[SPD_CFG_W-1:0];
                    CFG_SPEED_STEP_MIN: regs.speed_step_min = i_cfg.data[SPD_CFG_W-1:0];
                    CFG_SPEED_LIMIT:    regs.speed_limit    = i_cfg.data[SPD_CFG_W-1:0];
                    CFG_TURN_STEP_MAX:  regs.turn_step_max  = i_cfg.data[TRN_CFG_W-1:0];
                    CFG_TURN_STEP_MIN:  regs.turn_step_min  = i_cfg.data[TRN_CFG_W-1:0];
                    CFG_TURN_LIMIT:     regs.turn_limit     = i_cfg.data[TRN_CFG_W-1:0];
                    CFG_HALF_TRACK:     regs.half_track     = i_cfg.data[HT_W-1:0];
                    default: ;
                endcase
            end
            if (i_drive.valid && i_drive.ready) begin
                word_count++;
                if (drive_words_due.size() == 0) begin
                    report_mismatch($sformatf("drive word with none due, speed %0d turn %0d",
                                              i_drive.speed_now, i_drive.turn_now));
                end else begin
                    want = drive_words_due.pop_front();
                    check_field("left_forward", i_drive.left_forward, want.left_forward);
                    check_field("left_rate", i_drive.left_rate, want.left_rate);
                    check_field("right_forward", i_drive.right_forward, want.right_forward);
                    check_field("right_rate", i_drive.right_rate, want.right_rate);
                    check_field("speed_now", i_drive.speed_now, want.speed_now);
                    check_field("turn_now", i_drive.turn_now, want.turn_now);
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                v = ramp_toward(linear_now, i_tick.speed_target, i_tick.speed_step,
                                regs.speed_step_max, regs.speed_step_min, regs.speed_limit);
                w = ramp_toward(angular_now, i_tick.turn_target, i_tick.turn_step,
                                regs.turn_step_max, regs.turn_step_min, regs.turn_limit);
                if (v != linear_now || w != angular_now) begin
                    hw = w * int'(regs.half_track);
                    wheel_of(v * 100 - hw, want.left_forward, want.left_rate);
                    wheel_of(-(v * 100 + hw), want.right_forward, want.right_rate);
                    want.speed_now = SPD_W'(v);
                    want.turn_now = TRN_W'(w);
                    drive_words_due.push_back(want);
                end
                linear_now = v;
                angular_now = w;
            end
        end
        pending = drive_words_due.size();
    end

endmodule

### dv/ramped_differential_drive_mixer_tb.sv
module ramped_differential_drive_mixer_tb;
    import rdm_pkg::*;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;

    logic                    i_clk;
    logic                    i_rst_n;
    t_idle_mode              idle_mode;
    logic                    hold_off;
    logic signed [SPD_W-1:0] seen_speed;
    logic signed [TRN_W-1:0] seen_turn;
    int                      fail_count;
    int                      pending;
    int                      word_count;
    int                      tick_count;
    int                      setting_count;
    int                      stall_cycles;

    rdm_in_if  in_ch ();
    rdm_out_if out_ch ();
    rdm_cfg_if cfg_ch ();

    ramped_differential_drive_mixer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    rdm_drive_check u_drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (in_ch),
        .i_drive      (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_word_count (word_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side, with the long hold-off taking priority
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seen_speed <= '0;
            seen_turn <= '0;
        end else if (out_ch.valid && out_ch.ready) begin
            seen_speed <= out_ch.speed_now;
            seen_turn <= out_ch.turn_now;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off) begin
            out_ch.ready <= 1'b0;
        end else if (idle_mode == IDLE_RECEIVER) begin
            out_ch.ready <= ($urandom_range(99) >= 85);
        end else if (idle_mode == IDLE_BOTH) begin
            out_ch.ready <= ($urandom_range(99) >= 24);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_tick(input int target_spd, step_spd, target_trn, step_trn);
        while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 85) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 24)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.speed_target <= SPD_W'(target_spd);
        in_ch.speed_step <= SPD_W'(step_spd);
        in_ch.turn_target <= TRN_W'(target_trn);
        in_ch.turn_step <= TRN_W'(step_trn);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tick_count++;
    endtask

    task automatic load_cfg(input t_cfg c);
        logic [CFG_IDX_W-1:0]  order [8];
        logic [CFG_DATA_W-1:0] word;
        order = '{CFG_SPEED_STEP_MAX, CFG_SPEED_STEP_MIN, CFG_SPEED_LIMIT, CFG_TURN_STEP_MAX,
                  CFG_TURN_STEP_MIN, CFG_TURN_LIMIT, CFG_HALF_TRACK, CFG_UNUSED};
        for (int k = 0; k < 8; k++) begin
            // spare upper bits are random so masking gets exercised
            word = CFG_DATA_W'($urandom);
            case (order[k])
                CFG_SPEED_STEP_MAX: word[SPD_CFG_W-1:0] = c.speed_step_max;
                CFG_SPEED_STEP_MIN: word[SPD_CFG_W-1:0] = c.speed_step_min;
                CFG_SPEED_LIMIT:    word[SPD_CFG_W-1:0] = c.speed_limit;
                CFG_TURN_STEP_MAX:  word[TRN_CFG_W-1:0] = c.turn_step_max;
                CFG_TURN_STEP_MIN:  word[TRN_CFG_W-1:0] = c.turn_step_min;
                CFG_TURN_LIMIT:     word[TRN_CFG_W-1:0] = c.turn_limit;
                CFG_HALF_TRACK:     word[HT_W-1:0]      = c.half_track;
                default: ;
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= order[k];
            cfg_ch.data <= word;
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        setting_count++;
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.speed_step_max = SPD_CFG_W'($urandom_range(1, 600));
        c.speed_step_min = SPD_CFG_W'($urandom_range(0, 100));
        c.speed_limit    = SPD_CFG_W'($urandom);
        c.turn_step_max  = TRN_CFG_W'($urandom_range(1, 900));
        c.turn_step_min  = TRN_CFG_W'($urandom_range(0, 150));
        c.turn_limit     = TRN_CFG_W'($urandom);
        c.half_track     = HT_W'($urandom);
        return c;
    endfunction

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ramps toward a held goal, steered by the last reported values
    task automatic run_random(input int n);
        int                      goal_spd;
        int                      goal_trn;
        int                      hold;
        int                      pick;
        logic signed [SPD_W-1:0] ss;
        logic signed [TRN_W-1:0] ts;
        goal_spd = 0;
        goal_trn = 0;
        hold = 0;
        repeat (n) begin
            if (hold == 0) begin
                goal_spd = int'($urandom_range(4095)) - 2048;
                goal_trn = int'($urandom_range(8191)) - 4096;
                hold = int'($urandom_range(3, 24));
            end
            hold--;
            pick = int'($urandom_range(99));
            ss = SPD_W'($urandom_range(pick < 80 ? 300 : 2047));
            ts = TRN_W'($urandom_range(pick < 80 ? 500 : 4095));
            if (goal_spd < seen_speed) ss = -ss;
            if (goal_trn < seen_turn) ts = -ts;
            if (pick < 8) begin
                send_tick(SPD_W'($urandom), SPD_W'($urandom), TRN_W'($urandom), TRN_W'($urandom));
            end else if (pick < 12) begin
                send_tick(goal_spd, 0, goal_trn, 0);
            end else if (pick < 16) begin
                send_tick(goal_spd, -ss, goal_trn, -ts);
            end else begin
                send_tick(goal_spd, ss, goal_trn, ts);
            end
        end
    endtask

    task automatic run_phase(input t_cfg c, input t_idle_mode m, input int n, input bit squeeze);
        settle();
        load_cfg(c);
        idle_mode <= m;
        if (squeeze) begin
            fork
                begin
                    hold_off <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_off <= 1'b0;
                end
            join_none
        end
        run_random(n);
    endtask

    initial begin
        t_cfg wide_cfg;
        t_cfg crossed_cfg;
        t_cfg starved_cfg;
        wide_cfg    = '{11'd2047, 11'd0, 11'd2047, 12'd4095, 12'd0, 12'd4095, 8'd255};
        crossed_cfg = '{11'd5, 11'd40, 11'd600, 12'd3, 12'd50, 12'd900, 8'd0};
        starved_cfg = '{11'd0, 11'd2047, 11'd1, 12'd1, 12'd0, 12'd1, 8'd128};
        i_rst_n = 1'b0;
        idle_mode = IDLE_NONE;
        hold_off = 1'b0;
        tick_count = 0;
        setting_count = 0;
        in_ch.valid = 1'b0;
        in_ch.speed_target = '0;
        in_ch.speed_step = '0;
        in_ch.turn_target = '0;
        in_ch.turn_step = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no-change ticks, zero wheel, min raise, snap, limit clamp
        send_tick(0, 0, 0, 0);
        send_tick(0, 1234, 0, -999);
        send_tick(0, 0, 100, 1);
        send_tick(0, 0, 0, -1);
        send_tick(2047, 2047, 4095, 4095);
        send_tick(2047, -2048, -4096, -4096);
        send_tick(2047, 0, -4096, 0);
        send_tick(2047, 3, -4096, -3);
        send_tick(50, 1, -4096, -1);
        repeat (10) send_tick(2047, 2047, 4095, 4095);
        send_tick(1150, 0, 4095, 0);
        send_tick(-2048, -2048, -4096, -4096);

        run_phase(CFG_RESET, IDLE_SENDER, 180, 1'b0);
        run_phase(wide_cfg, IDLE_RECEIVER, 200, 1'b1);
        run_phase(crossed_cfg, IDLE_BOTH, 180, 1'b0);
        run_phase(random_cfg(), IDLE_NONE, 180, 1'b1);
        run_phase(starved_cfg, IDLE_SENDER, 100, 1'b0);
        run_phase(random_cfg(), IDLE_BOTH, 180, 1'b0);
        run_phase(CFG_RESET, IDLE_RECEIVER, 260, 1'b0);
        settle();

        $display("%0d ticks sent across %0d register loads, %0d drive words compared",
                 tick_count, setting_count, word_count);
        $display("phases mixed free flow, sender gaps, receiver stalls and held-off output");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
